// ===== hw/rtl/aigdec_pkg.sv =====
// Package for the AIG binary AND-section decoder: widths, status codes and helpers.
package aigdec_pkg;

   localparam int unsigned CfgWidth  = 30;
   localparam int unsigned LitWidth  = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned DigitBits = 7;
   // Number of 7-bit digits that fit below bit 32 before the final short one.
   localparam int unsigned MaxDigits = 4;
   localparam int unsigned CntWidth  = 3;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_OVERFLOW    = 3'd1,
      STATUS_BAD_D1      = 3'd2,
      STATUS_BAD_D2      = 3'd3,
      STATUS_NON_TOPO    = 3'd4,
      STATUS_UNEXPECTED  = 3'd5
   } status_type;

   typedef enum logic {
      CSR_BASE_VAR   = 1'b0,
      CSR_GATE_COUNT = 1'b1
   } csr_index_type;

endpackage

// ===== hw/rtl/aig_binary_and_gate_decoder.sv =====
// Top level of the AIG binary AND-section decoder with varint and delta decoding.
// An accepted byte waits in the input register; a gate it completes goes to the result register.
// Throughput: one byte per cycle while the result side is ready; all decoding for a byte is
// combinational between the input register and the result register.
// Reset is synchronous: it clears the decoder state, both valid flags and the CSRs.
// After an error or the final gate the decoder drops all bytes until the next reset.
module aig_binary_and_gate_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [aigdec_pkg::CfgWidth-1:0]     csr_wdata,
   // Byte stream in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [aigdec_pkg::ByteWidth-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // end_of_data
   // Gate results out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [3*aigdec_pkg::LitWidth-1:0]   rsp_tdata,   // [31:0] lhs_literal,
                                                            // [63:32] rhs0_literal,
                                                            // [95:64] rhs1_literal
   output logic                                rsp_tlast,   // last_gate
   output logic [2:0]                          rsp_tuser    // [2:0] status
);
   import aigdec_pkg::*;

   // Configuration registers
   logic [CfgWidth-1:0] base_var_ff, gate_count_ff;

   // Input register
   logic                 s1_valid_ff;
   logic [ByteWidth-1:0] s1_byte_ff;
   logic                 s1_eod_ff;

   // Decoder state
   logic [LitWidth-1:0] accum_ff, accum_in;
   logic [CntWidth-1:0] digits_ff, digits_in;
   logic                phase_ff, phase_in;
   logic [LitWidth-1:0] held_rhs0_ff, held_rhs0_in;
   logic [CfgWidth-1:0] gate_index_ff, gate_index_in;
   logic                halted_ff, halted_in;

   // Result register
   logic                rsp_valid_ff;
   logic [LitWidth-1:0] lhs_ff, rhs0_ff, rhs1_ff;
   logic                last_ff;
   status_type          status_ff;

   // Combinational decode results
   logic                emit;
   logic [LitWidth-1:0] lhs, rhs0_out, rhs1_out, value, shifted, rhs0_sub, rhs1_sub;
   logic                last_out;
   status_type          status_out;
   logic [CfgWidth:0]   var_sum;
   logic [CfgWidth:0]   next_index;
   logic                active, proc;
   logic [DigitBits-1:0] payload;

   assign proc       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || proc;
   assign active     = !halted_ff && (gate_index_ff < gate_count_ff);

   // lhs = 2 * (base_var + gate_index + 1), kept to 32 bits.
   assign var_sum    = {1'b0, base_var_ff} + {1'b0, gate_index_ff} + {{CfgWidth{1'b0}}, 1'b1};
   assign lhs        = {var_sum[LitWidth-2:0], 1'b0};
   assign next_index = {1'b0, gate_index_ff} + {{CfgWidth{1'b0}}, 1'b1};
   assign payload    = s1_byte_ff[DigitBits-1:0];

   always_comb begin
      case (digits_ff)
         3'd0:    shifted = {25'd0, payload};
         3'd1:    shifted = {18'd0, payload, 7'd0};
         3'd2:    shifted = {11'd0, payload, 14'd0};
         3'd3:    shifted = {4'd0, payload, 21'd0};
         3'd4:    shifted = {payload[3:0], 28'd0};
         default: shifted = '0;
      endcase
   end

   assign value    = accum_ff | shifted;
   assign rhs0_sub = lhs - value;
   assign rhs1_sub = held_rhs0_ff - value;

   always_comb begin
      accum_in      = accum_ff;
      digits_in     = digits_ff;
      phase_in      = phase_ff;
      held_rhs0_in  = held_rhs0_ff;
      gate_index_in = gate_index_ff;
      halted_in     = halted_ff;
      emit          = 1'b0;
      rhs0_out      = '0;
      rhs1_out      = '0;
      last_out      = 1'b0;
      status_out    = STATUS_OK;
      if (proc && active) begin
         if (s1_byte_ff[ByteWidth-1]) begin
            // Continuation byte: more digits follow.
            accum_in = value;
            rhs0_out = phase_ff ? held_rhs0_ff : '0;
            if (digits_ff == CntWidth'(MaxDigits)) begin
               emit       = 1'b1;
               status_out = STATUS_OVERFLOW;
            end else begin
               digits_in = digits_ff + 3'd1;
               if (s1_eod_ff) begin
                  emit       = 1'b1;
                  status_out = STATUS_UNEXPECTED;
               end
            end
         end else begin
            accum_in  = '0;
            digits_in = '0;
            if (!phase_ff) begin
               if (value > lhs) begin
                  emit       = 1'b1;
                  status_out = STATUS_BAD_D1;
               end else begin
                  held_rhs0_in = rhs0_sub;
                  phase_in     = 1'b1;
                  if (s1_eod_ff) begin
                     emit       = 1'b1;
                     rhs0_out   = rhs0_sub;
                     status_out = STATUS_UNEXPECTED;
                  end
               end
            end else begin
               phase_in = 1'b0;
               rhs0_out = held_rhs0_ff;
               emit     = 1'b1;
               if (value > held_rhs0_ff) begin
                  status_out = STATUS_BAD_D2;
               end else begin
                  rhs1_out = rhs1_sub;
                  // The fanin variables must lie below the gate's own variable.
                  if ((held_rhs0_ff[LitWidth-1:1] >= lhs[LitWidth-1:1]) ||
                      (rhs1_sub[LitWidth-1:1] >= lhs[LitWidth-1:1])) begin
                     status_out = STATUS_NON_TOPO;
                  end else begin
                     gate_index_in = next_index[CfgWidth-1:0];
                     if (next_index >= {1'b0, gate_count_ff}) begin
                        last_out  = 1'b1;
                        halted_in = 1'b1;
                     end else if (s1_eod_ff) begin
                        status_out = STATUS_UNEXPECTED;
                     end
                  end
               end
            end
         end
         if (emit && (status_out != STATUS_OK)) begin
            halted_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_var_ff   <= '0;
         gate_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_VAR:   base_var_ff   <= csr_wdata;
            CSR_GATE_COUNT: gate_count_ff <= csr_wdata;
            default:        base_var_ff   <= base_var_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
         s1_eod_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= '0;
         digits_ff     <= '0;
         phase_ff      <= 1'b0;
         held_rhs0_ff  <= '0;
         gate_index_ff <= '0;
         halted_ff     <= 1'b0;
      end else begin
         accum_ff      <= accum_in;
         digits_ff     <= digits_in;
         phase_ff      <= phase_in;
         held_rhs0_ff  <= held_rhs0_in;
         gate_index_ff <= gate_index_in;
         halted_ff     <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         lhs_ff    <= lhs;
         rhs0_ff   <= rhs0_out;
         rhs1_ff   <= rhs1_out;
         last_ff   <= last_out;
         status_ff <= status_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rhs1_ff, rhs0_ff, lhs_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = status_ff;

endmodule

// ===== hw/rtl/aigdec_checker.sv =====
// Port-level checker for the AIG binary AND-section decoder, with its bind statement.
module aigdec_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [3*aigdec_pkg::LitWidth-1:0]   rsp_tdata,
   input logic                                rsp_tlast,
   input logic [2:0]                          rsp_tuser
);
   import aigdec_pkg::*;

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The final gate is only flagged on a clean result.
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == STATUS_OK)
      else $error("last gate flagged with an error status");

   // Once an error or the final gate has been delivered, the decoder goes silent.
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tlast || rsp_tuser != STATUS_OK) |=> !rsp_tvalid)
      else $error("result after the decoder halted");

   // A clean gate has even lhs and fanins that do not exceed it.
   a_clean_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OK |->
         !rsp_tdata[0] && (rsp_tdata[63:32] <= rsp_tdata[31:0]) &&
         (rsp_tdata[95:64] <= rsp_tdata[63:32]))
      else $error("inconsistent literals on a clean gate");

endmodule

bind aig_binary_and_gate_decoder aigdec_checker u_aigdec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
